// ----- hdl/rtc_snapshot_to_datetime_defines.svh -----
// Assertion macros shared by the RTC snapshot decoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef RTC_SNAPSHOT_TO_DATETIME_DEFINES_SVH
`define RTC_SNAPSHOT_TO_DATETIME_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/rtcsd_pkg.sv -----
// Types, constants and helper functions for the RTC snapshot decoder.
// No dependencies.
package rtcsd_pkg;

    localparam int unsigned SnapW   = 48;
    localparam int unsigned OutW    = 51;
    localparam int unsigned OutTdW  = 56;

    localparam logic [7:0]  PmFlag      = 8'h80;
    localparam logic [7:0]  NoonHour    = 8'd12;
    localparam logic [7:0]  YearPivot   = 8'd70;
    localparam logic [11:0] CenturyNew  = 12'd2000;
    localparam logic [11:0] CenturyOld  = 12'd1900;

    // configuration register indexes
    localparam logic CfgHour24 = 1'b0;
    localparam logic CfgBinary = 1'b1;

    typedef struct packed {
        logic hour_24;
        logic binary;
    } t_cfg;

    typedef struct packed {
        logic match;
        logic have_prev;
    } t_pair_status;

    typedef struct packed {
        logic [11:0] full_year;
        logic [7:0]  month_number;
        logic [7:0]  day_of_month;
        logic [6:0]  hours;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
    } t_datetime;

    // high nibble * 10 + low nibble, wrapped to 8 bits
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    endfunction

    // x mod 3 for a 5-bit value: base-4 digit sum, then fold
    function automatic logic [1:0] mod3_5b(input logic [4:0] x);
        logic [2:0] s;
        logic [2:0] t;
        s = {1'b0, x[1:0]} + {1'b0, x[3:2]} + {2'b00, x[4]};
        t = {1'b0, s[1:0]} + {2'b00, s[2]};
        return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    endfunction

    // x mod 24 = ((x >> 3) mod 3) * 8 + low three bits
    function automatic logic [7:0] mod24(input logic [7:0] x);
        return {3'b000, mod3_5b(x[7:3]), x[2:0]};
    endfunction

endpackage

// ----- hdl/rtcsd_pair.sv -----
// Snapshot pairing: holds the last clean snapshot and flags a repeat.
// Depends on rtcsd_pkg.
module rtcsd_pair (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rtcsd_pkg::SnapW-1:0] i_snap,
    input  logic                       i_consume,
    output rtcsd_pkg::t_pair_status    o_status
);

    logic [rtcsd_pkg::SnapW-1:0] r_prev;
    logic                        r_have_prev;
    logic [rtcsd_pkg::SnapW-1:0] n_prev;
    logic                        n_have_prev;
    logic                        w_match;

    assign w_match = r_have_prev && (i_snap == r_prev);

    always_comb begin
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        if (i_consume) begin
            if (w_match) begin
                n_have_prev = 1'b0;
            end else begin
                n_prev      = i_snap;
                n_have_prev = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
        end
    end

    assign o_status.match     = w_match;
    assign o_status.have_prev = r_have_prev;

endmodule

// ----- hdl/rtcsd_decode.sv -----
// Combinational BCD/binary decode, 12/24-hour mapping and year windowing.
// Depends on rtcsd_pkg.
module rtcsd_decode (
    input  logic [rtcsd_pkg::SnapW-1:0] i_snap,
    input  rtcsd_pkg::t_cfg             i_cfg,
    output rtcsd_pkg::t_datetime        o_dt
);

    logic [7:0] w_raw [6];
    logic [7:0] w_dec [6];
    logic       w_pm;
    logic [7:0] w_hour;
    logic [7:0] w_year;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_raw[i] = i_snap[8*i +: 8];
        end
        w_pm     = w_raw[2][7];
        w_raw[2] = w_raw[2] & ~rtcsd_pkg::PmFlag;
        for (int i = 0; i < 6; i++) begin
            w_dec[i] = i_cfg.binary ? w_raw[i] : rtcsd_pkg::bcd_value(w_raw[i]);
        end

        w_hour = w_dec[2];
        if (!i_cfg.hour_24) begin
            if (w_dec[2] == rtcsd_pkg::NoonHour) begin
                if (!w_pm) w_hour = 8'd0;
            end else if (w_pm) begin
                // input is at most 127, so the sum fits in 8 bits
                w_hour = rtcsd_pkg::mod24(w_dec[2] + rtcsd_pkg::NoonHour);
            end
        end

        w_year = w_dec[5];
        o_dt.seconds      = w_dec[0];
        o_dt.minutes      = w_dec[1];
        o_dt.hours        = w_hour[6:0];
        o_dt.day_of_month = w_dec[3];
        o_dt.month_number = w_dec[4];
        o_dt.full_year    = {4'd0, w_year} + ((w_year < rtcsd_pkg::YearPivot) ?
                            rtcsd_pkg::CenturyNew : rtcsd_pkg::CenturyOld);
    end

endmodule

// ----- hdl/rtc_snapshot_to_datetime.sv -----
// RTC register snapshot to calendar date/time decoder, top level.
// Depends on rtcsd_pkg, rtcsd_pair, rtcsd_decode and the defines header.
//
// Usage:
//   Input stream: tdata carries the six raw clock bytes, tuser the
//   update-in-progress flag. Busy transactions are dropped at the port.
//   A clean snapshot is held in an input register; it produces a result
//   only if it equals the previous clean snapshot, after which a fresh
//   pair is needed. Non-matching snapshots are absorbed and stored.
//   Output stream: one decoded date/time per match, from a result register.
//   Path: the input register, then the result register, which drives o_m_axis_tvalid.
//   Throughput: one transaction per cycle unless stalled (see Stall); the decode
//   and the compare sit in one register-to-register step.
//   Stall: while the result register is full and not taken, a matching
//   snapshot waits in the input register and input ready drops; a
//   non-matching one still drains.
//   Reset (synchronous, active low): pipeline emptied, pairing cleared,
//   24-hour mode and BCD mode selected.
//   Config: write enable, index (0 = hour_format_24, 1 = binary_mode), data;
//   write only while idle.
`include "rtc_snapshot_to_datetime_defines.svh"

module rtc_snapshot_to_datetime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // raw_seconds, raw_minutes, raw_hours, raw_day, raw_month, raw_year
    input  logic [47:0] i_s_axis_tdata,
    // update_busy
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // seconds[7:0], minutes[15:8], hours[22:16], day_of_month[30:23],
    // month_number[38:31], full_year[50:39], zero fill above
    output logic [55:0] o_m_axis_tdata
);

    rtcsd_pkg::t_cfg             r_cfg;
    logic                        r_in_valid;
    logic [rtcsd_pkg::SnapW-1:0] r_in_data;
    logic                        r_out_valid;
    rtcsd_pkg::t_datetime        r_out_data;

    rtcsd_pkg::t_pair_status     w_pair;
    rtcsd_pkg::t_datetime        w_dt;
    logic                        w_out_free;
    logic                        w_s1_go;
    logic                        w_out_load;
    logic                        w_s_fire;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_s1_go         = r_in_valid && (w_out_free || !w_pair.match);
    assign w_out_load      = w_s1_go && w_pair.match;
    assign o_s_axis_tready = !r_in_valid || w_s1_go;
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hour_24 <= 1'b1;
            r_cfg.binary  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtcsd_pkg::CfgHour24: r_cfg.hour_24 <= i_cfg_wdata;
                rtcsd_pkg::CfgBinary: r_cfg.binary  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register: busy snapshots never enter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= w_s_fire && !i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    rtcsd_pair u_pair (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_snap    (r_in_data),
        .i_consume (w_s1_go),
        .o_status  (w_pair)
    );

    rtcsd_decode u_decode (
        .i_snap (r_in_data),
        .i_cfg  (r_cfg),
        .o_dt   (w_dt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_dt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(rtcsd_pkg::OutTdW - rtcsd_pkg::OutW){1'b0}}, r_out_data};

    // a delivered match always restarts the pairing
    `RTCSD_ASSERT_NEXT(a_match_clears_pair, i_clk, i_rst_n, w_out_load, !w_pair.have_prev)
    // busy transactions leave the input register empty
    `RTCSD_ASSERT_NEXT(a_busy_dropped, i_clk, i_rst_n, w_s_fire && i_s_axis_tuser, !r_in_valid)
    // a match blocked by a full result register waits with its data intact
    `RTCSD_ASSERT_NEXT(a_match_waits, i_clk, i_rst_n,
        r_in_valid && w_pair.match && !w_out_free, r_in_valid && $stable(r_in_data))
    // a result is only loaded from a held snapshot that had a partner
    `RTCSD_ASSERT_IMPL(a_load_has_prev, i_clk, i_rst_n, w_out_load,
        r_in_valid && w_pair.have_prev)

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for rtc_snapshot_to_datetime: directed table, then random phases.
// Uses rtcsd_pkg for the result layout and register indexes; predicts results in-line.
`timescale 1ns / 1ps

module tb;

    localparam int StallLimit = 4000;
    localparam int HoldCycles = 200;
    localparam int PhaseItems = 105;
    localparam int NumRows    = 24;

    typedef struct packed {
        logic                 h24;
        logic                 bin;
        logic                 busy;
        logic                 typed;
        logic [47:0]          snap;
        rtcsd_pkg::t_datetime dt;
    } t_dir_row;

    // snapshot literals read as year_month_day_hour_min_sec
    localparam t_dir_row DirRows [NumRows] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h00_00_00_00_00_00, '0},
        '{1'b1, 1'b0, 1'b0, 1'b1, 48'h00_00_00_00_00_00,
          '{12'd2000, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0}},
        '{1'b1, 1'b0, 1'b1, 1'b0, 48'hff_ff_ff_ff_ff_ff, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'hff_ff_ff_ff_ff_ff, '0},
        '{1'b1, 1'b0, 1'b1, 1'b0, 48'h12_34_56_78_9a_bc, '0},
        '{1'b1, 1'b0, 1'b0, 1'b1, 48'hff_ff_ff_ff_ff_ff,
          '{12'd2065, 8'd165, 8'd165, 7'd85, 8'd165, 8'd165}},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h69_12_31_23_59_59, '0},
        '{1'b1, 1'b0, 1'b0, 1'b1, 48'h69_12_31_23_59_59,
          '{12'd2069, 8'd12, 8'd31, 7'd23, 8'd59, 8'd59}},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h70_01_01_00_00_00, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h70_01_01_00_00_00, '0},
        // pairing restarted: a third copy only arms, then a different one re-arms
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h70_01_01_00_00_00, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h70_01_01_00_00_02, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h70_01_01_00_00_02, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h24_06_15_92_30_45, '0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 48'h24_06_15_92_30_45, '0},
        // 12-hour BCD: midnight, noon, PM on an out-of-range hour
        '{1'b0, 1'b0, 1'b0, 1'b0, 48'h99_07_04_12_00_00, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 48'h99_07_04_12_00_00, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 48'h00_02_29_92_00_00, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 48'h00_02_29_92_00_00, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 48'h01_01_01_ff_00_00, '0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 48'h01_01_01_ff_00_00, '0},
        '{1'b1, 1'b1, 1'b0, 1'b0, 48'hff_ff_ff_ff_ff_ff, '0},
        '{1'b1, 1'b1, 1'b0, 1'b1, 48'hff_ff_ff_ff_ff_ff,
          '{12'd2155, 8'd255, 8'd255, 7'd127, 8'd255, 8'd255}},
        '{1'b0, 1'b1, 1'b0, 1'b0, 48'h45_0c_1f_8c_3b_3b, '0}
    };

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_index     = rtcsd_pkg::CfgHour24;
    logic        i_cfg_wdata     = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // raw_seconds, raw_minutes, raw_hours, raw_day, raw_month, raw_year
    logic [47:0] i_s_axis_tdata  = '0;
    // update_busy
    logic        i_s_axis_tuser  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // seconds, minutes, hours, day_of_month, month_number, full_year, zero fill
    logic [55:0] o_m_axis_tdata;

    // tags riding along with the current input transaction
    logic                 row_typed = 1'b0;
    rtcsd_pkg::t_datetime row_dt    = '0;

    rtcsd_pkg::t_datetime pending_datetimes [$];
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    bit          hold_pending   = 1'b0;
    logic        cur_h24        = 1'b1;
    logic        cur_bin        = 1'b0;

    // predictor state
    logic        model_h24       = 1'b1;
    logic        model_bin       = 1'b0;
    logic [47:0] last_clean_snap = '0;
    logic        snap_armed      = 1'b0;

    rtc_snapshot_to_datetime DUT (.*);

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic rtcsd_pkg::t_datetime decode_datetime(input logic [47:0] snap,
                                                             input logic h24,
                                                             input logic bin);
        logic [7:0]           b [6];
        logic                 pm;
        int unsigned          hr;
        rtcsd_pkg::t_datetime dt;
        pm = snap[23];
        for (int k = 0; k < 6; k++) begin
            b[k] = snap[8*k +: 8];
            if (k == 2) b[k][7] = 1'b0;
            if (!bin) b[k] = 8'(b[k][7:4] * 10 + b[k][3:0]);
        end
        hr = b[2];
        if (!h24) begin
            if (hr == rtcsd_pkg::NoonHour) begin
                if (!pm) hr = 0;
            end else if (pm) begin
                hr = (hr + rtcsd_pkg::NoonHour) % 24;
            end
        end
        dt.seconds      = b[0];
        dt.minutes      = b[1];
        dt.hours        = 7'(hr);
        dt.day_of_month = b[3];
        dt.month_number = b[4];
        dt.full_year    = (b[5] < rtcsd_pkg::YearPivot) ? rtcsd_pkg::CenturyNew + b[5] :
                          rtcsd_pkg::CenturyOld + b[5];
        return dt;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // scoreboard: outputs checked before the same edge's input is predicted
    always @(posedge i_clk) begin : monitor
        rtcsd_pkg::t_datetime got;
        rtcsd_pkg::t_datetime want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtcsd_pkg::CfgHour24: model_h24 = i_cfg_wdata;
                    rtcsd_pkg::CfgBinary: model_bin = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[50:0];
                if (pending_datetimes.size() == 0) begin
                    $error("result with no pending snapshot match: %h", o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_datetimes.pop_front();
                    check_field("seconds", want.seconds, got.seconds);
                    check_field("minutes", want.minutes, got.minutes);
                    check_field("hours", want.hours, got.hours);
                    check_field("day_of_month", want.day_of_month, got.day_of_month);
                    check_field("month_number", want.month_number, got.month_number);
                    check_field("full_year", want.full_year, got.full_year);
                    check_field("tdata_fill", 0, o_m_axis_tdata[55:51]);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser) begin
                if (snap_armed && i_s_axis_tdata == last_clean_snap) begin
                    snap_armed = 1'b0;
                    pending_datetimes.push_back(row_typed ? row_dt :
                        decode_datetime(i_s_axis_tdata, model_h24, model_bin));
                end else begin
                    last_clean_snap = i_s_axis_tdata;
                    snap_armed      = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == StallLimit) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result sink: random backpressure plus one long hold-off
    always begin
        @(negedge i_clk);
        if (hold_pending) begin
            hold_pending = 1'b0;
            i_m_axis_tready <= 1'b0;
            repeat (HoldCycles) @(negedge i_clk);
        end
        i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic offer(input logic [47:0] snap, input logic busy,
                         input logic typed = 1'b0, input rtcsd_pkg::t_datetime dt = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= snap;
        i_s_axis_tuser  <= busy;
        row_typed       <= typed;
        row_dt          <= dt;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_results(input int extra);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_datetimes.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic h24, input logic bin);
        wait_results(4);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rtcsd_pkg::CfgHour24;
        i_cfg_wdata <= h24;
        @(negedge i_clk);
        i_cfg_index <= rtcsd_pkg::CfgBinary;
        i_cfg_wdata <= bin;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_h24 = h24;
        cur_bin = bin;
    endtask

    // mostly in-range values in the current encoding, some raw bytes
    function automatic logic [7:0] rand_field(input int lo, input int hi);
        int v;
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        v = $urandom_range(hi, lo);
        return cur_bin ? 8'(v) : {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [47:0] rand_snapshot();
        logic [7:0] hr;
        hr = cur_h24 ? rand_field(0, 23) : rand_field(1, 12);
        if ($urandom_range(cur_h24 ? 7 : 1) == 0) hr[7] = 1'b1;
        return {rand_field(0, 99), rand_field(1, 12), rand_field(1, 31), hr,
                rand_field(0, 59), rand_field(0, 59)};
    endfunction

    initial begin : stimulus
        logic [47:0] snap;
        int          sent;
        int          pairs;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DirRows[r]) begin
            if (DirRows[r].h24 != cur_h24 || DirRows[r].bin != cur_bin)
                write_cfg(DirRows[r].h24, DirRows[r].bin);
            offer(DirRows[r].snap, DirRows[r].busy, DirRows[r].typed, DirRows[r].dt);
        end

        for (int p = 0; p < 12; p++) begin
            write_cfg((p / 3) % 2 == 0, p / 3 >= 2);
            case (p % 3)
                0: begin tx_idle_pct = 6;  rx_idle_pct = 74; end
                1: begin tx_idle_pct = 74; rx_idle_pct = 6;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (p == 2) hold_pending = 1'b1;
            sent  = 0;
            pairs = 0;
            while (sent < PhaseItems) begin
                snap = rand_snapshot();
                offer(snap, 1'b0);
                sent++;
                if ($urandom_range(4) == 0) offer(48'({$urandom(), $urandom()}), 1'b1);
                case ($urandom_range(9))
                    0, 1: ;  // left unpaired
                    2: begin
                        // near miss: one bit off
                        offer(snap ^ (48'd1 << $urandom_range(47)), 1'b0);
                        sent++;
                    end
                    default: begin
                        offer(snap, 1'b0);
                        sent++;
                        if ($urandom_range(7) == 0) begin
                            offer(snap, 1'b0);
                            sent++;
                        end
                    end
                endcase
                pairs++;
                if (pairs % 40 == 39) wait_results(0);
            end
        end

        wait_results(6);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
